### design/mersenne_twister_generator_defines.svh
// Assertion macros shared by the generator RTL.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Check prop at every clock edge outside reset.
`define MTG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check prop at every clock edge, reset included.
`define MTG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define MTG_ASSERT(label, clk, rst_n, prop, msg)
`define MTG_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### design/mtg_pkg.sv
package mtg_pkg;

    typedef logic [31:0] word_t;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int TWIST_BACK   = STATE_WORDS - TWIST_OFFSET;
    localparam int SAW          = $clog2(STATE_WORDS + 2);

    typedef logic [SAW-1:0] saddr_t;

    localparam saddr_t LAST_WORD    = saddr_t'(STATE_WORDS - 1);
    localparam saddr_t POS_EXPIRED  = saddr_t'(STATE_WORDS);
    localparam saddr_t NEVER_SEEDED = saddr_t'(STATE_WORDS + 1);

    localparam logic [1:0] OP_SEED     = 2'd0;
    localparam logic [1:0] OP_KEY      = 2'd1;
    localparam logic [1:0] OP_KEY_SEED = 2'd2;
    localparam logic [1:0] OP_DRAW     = 2'd3;

    localparam word_t TWIST_MATRIX = 32'h9908b0df;
    localparam word_t TEMPER_B     = 32'h9d2c5680;
    localparam word_t TEMPER_C     = 32'hefc60000;
    localparam word_t INIT_MULT    = 32'd1812433253;
    localparam word_t KEY_MULT_A   = 32'd1664525;
    localparam word_t KEY_MULT_B   = 32'd1566083941;
    localparam word_t KEY_SEED     = 32'd19650218;
    localparam word_t DEFAULT_SEED = 32'd5489;
    localparam word_t HIGH_BIT     = 32'h80000000;

endpackage

### design/mtg_ram.sv
module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/mersenne_twister_generator.sv
// Channel  Ports                                           Word
// s_       s_valid s_ready s_op s_value s_key_index        one command
//          s_key_count
// m_       m_valid m_ready m_random_word m_word_valid      one result per command
//
// Command flow: since the memory read is registered, the key and twist sweeps
// take a read step and an update step per table word. A draw that finds the
// table used up first runs the twist sweep, and a draw before any seeding
// first seeds the table with the default seed and then runs the twist sweep.
// Reset: synchronous, active low; clears control state and marks the table as
//   never seeded. Table and key store contents are undefined until written.
// Stalls: a held result blocks only the last step of the next command.
module mersenne_twister_generator
    import mtg_pkg::*;
#(
    parameter int MAX_KEY_WORDS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [31:0] s_value,
    input  logic [3:0]  s_key_index,
    input  logic [4:0]  s_key_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word,
    output logic        m_word_valid
);

`include "mersenne_twister_generator_defines.svh"

    localparam int KAW = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int CW  = $clog2(MAX_KEY_WORDS + 1);

    // Sequencer codes
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SEED     = 4'd1;
    localparam logic [3:0] ST_K1_RD    = 4'd2;
    localparam logic [3:0] ST_K1_EX    = 4'd3;
    localparam logic [3:0] ST_K2_RD    = 4'd4;
    localparam logic [3:0] ST_K2_EX    = 4'd5;
    localparam logic [3:0] ST_KFIN     = 4'd6;
    localparam logic [3:0] ST_TW_START = 4'd7;
    localparam logic [3:0] ST_TW_FIRST = 4'd8;
    localparam logic [3:0] ST_TW_RD    = 4'd9;
    localparam logic [3:0] ST_TW_EX    = 4'd10;
    localparam logic [3:0] ST_DR_RD    = 4'd11;
    localparam logic [3:0] ST_DR_EX    = 4'd12;
    localparam logic [3:0] ST_EMIT     = 4'd13;

    logic [3:0]     state_reg;
    saddr_t         pos_reg;       // read position, NEVER_SEEDED after reset
    saddr_t         idx_reg;       // table index of the current sweep
    saddr_t         iter_reg;      // iterations done in the current key loop
    logic [KAW-1:0] j_reg;         // key store index
    logic [CW-1:0]  count_reg;     // saturated key count
    logic [1:0]     op_reg;
    word_t          seed_val_reg;
    word_t          p_reg;         // previous word of the seeding recurrences
    word_t          prod_reg;      // registered multiplier output
    logic           hi_reg;        // top bit of table word idx
    word_t          res_word_reg;
    logic           res_flag_reg;
    logic           m_valid_reg;
    word_t          m_word_reg;
    logic           m_flag_reg;

    // Memory ports: two copies of the table, written together, give two reads
    logic           mt_we;
    saddr_t         mt_waddr;
    word_t          mt_wdata;
    saddr_t         mt_raddr_a;
    saddr_t         mt_raddr_b;
    word_t          mt_rdata_a;
    word_t          mt_rdata_b;
    logic           key_we;
    logic [KAW-1:0] key_waddr;
    word_t          key_rdata;

    word_t          mix_w;
    word_t          mult_c;
    word_t          mult_out;
    word_t          twist_y;
    word_t          twist_v;
    word_t          t1;
    word_t          t2;
    word_t          t3;
    word_t          tempered;
    word_t          key_mix;
    word_t          key_fold;
    logic [CW-1:0]  count_next;
    logic [CW-1:0]  j_inc;
    logic           accept;
    logic           emit_go;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;
    assign m_word_valid  = m_flag_reg;

    // Clamp the key count into 1..MAX_KEY_WORDS
    always_comb begin
        if (s_key_count == 5'd0) begin
            count_next = CW'(1);
        end else if (32'(s_key_count) > MAX_KEY_WORDS) begin
            count_next = CW'(MAX_KEY_WORDS);
        end else begin
            count_next = CW'(s_key_count);
        end
    end

    assign j_inc = CW'(j_reg) + CW'(1);

    // One shared multiplier for all three seeding recurrences
    always_comb begin
        case (state_reg)
            ST_K1_RD: mult_c = KEY_MULT_A;
            ST_K2_RD: mult_c = KEY_MULT_B;
            default:  mult_c = INIT_MULT;
        endcase
    end

    assign mix_w    = p_reg ^ (p_reg >> 30);
    assign mult_out = mix_w * mult_c;

    assign key_mix  = (mt_rdata_a ^ prod_reg) + key_rdata + 32'(j_reg);
    assign key_fold = (mt_rdata_a ^ prod_reg) - 32'(idx_reg);

    // Twist of word idx from words idx+1 and idx+397
    assign twist_y = {hi_reg, mt_rdata_a[30:0]};
    assign twist_v = mt_rdata_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : 32'd0);

    // Tempering
    assign t1       = mt_rdata_a ^ (mt_rdata_a >> 11);
    assign t2       = t1 ^ ((t1 << 7) & TEMPER_B);
    assign t3       = t2 ^ ((t2 << 15) & TEMPER_C);
    assign tempered = t3 ^ (t3 >> 18);

    // Memory control
    always_comb begin
        mt_we      = 1'b0;
        mt_waddr   = idx_reg;
        mt_wdata   = twist_v;
        mt_raddr_a = idx_reg;
        mt_raddr_b = idx_reg;
        case (state_reg)
            ST_SEED: begin
                mt_we    = 1'b1;
                mt_wdata = (idx_reg == '0) ? seed_val_reg : mult_out + 32'(idx_reg);
            end
            ST_K1_EX: begin
                mt_we    = 1'b1;
                mt_wdata = key_mix;
            end
            ST_K2_EX: begin
                mt_we    = 1'b1;
                mt_wdata = key_fold;
            end
            ST_KFIN: begin
                mt_we    = 1'b1;
                mt_waddr = '0;
                mt_wdata = HIGH_BIT;
            end
            ST_TW_START: begin
                mt_raddr_a = '0;
            end
            ST_TW_RD: begin
                mt_raddr_a = (idx_reg == LAST_WORD) ? saddr_t'(0) : idx_reg + saddr_t'(1);
                mt_raddr_b = (32'(idx_reg) < TWIST_BACK) ?
                             idx_reg + saddr_t'(TWIST_OFFSET) :
                             idx_reg - saddr_t'(TWIST_BACK);
            end
            ST_TW_EX: begin
                mt_we = 1'b1;
            end
            ST_DR_RD: begin
                mt_raddr_a = pos_reg;
            end
            default: begin
            end
        endcase
    end

    assign key_we    = accept && (s_op == OP_KEY) && (32'(s_key_index) < MAX_KEY_WORDS);
    assign key_waddr = KAW'(s_key_index);

    mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_table_a (
        .clk   (aclk),
        .we    (mt_we),
        .waddr (mt_waddr),
        .wdata (mt_wdata),
        .raddr (mt_raddr_a),
        .rdata (mt_rdata_a)
    );

    mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_table_b (
        .clk   (aclk),
        .we    (mt_we),
        .waddr (mt_waddr),
        .wdata (mt_wdata),
        .raddr (mt_raddr_b),
        .rdata (mt_rdata_b)
    );

    mtg_ram #(.WIDTH(32), .DEPTH(MAX_KEY_WORDS)) u_keys (
        .clk   (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (s_value),
        .raddr (j_reg),
        .rdata (key_rdata)
    );

    // Sequencer and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= NEVER_SEEDED;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg    <= s_op;
                        count_reg <= count_next;
                        idx_reg   <= '0;
                        case (s_op)
                            OP_SEED: begin
                                seed_val_reg <= s_value;
                                state_reg    <= ST_SEED;
                            end
                            OP_KEY_SEED: begin
                                seed_val_reg <= KEY_SEED;
                                state_reg    <= ST_SEED;
                            end
                            OP_DRAW: begin
                                seed_val_reg <= DEFAULT_SEED;
                                if (pos_reg == NEVER_SEEDED) begin
                                    state_reg <= ST_SEED;
                                end else if (pos_reg == POS_EXPIRED) begin
                                    state_reg <= ST_TW_START;
                                end else begin
                                    state_reg <= ST_DR_RD;
                                end
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_SEED: begin
                    p_reg   <= mt_wdata;
                    idx_reg <= idx_reg + saddr_t'(1);
                    if (idx_reg == LAST_WORD) begin
                        pos_reg <= POS_EXPIRED;
                        case (op_reg)
                            OP_KEY_SEED: begin
                                p_reg     <= seed_val_reg;
                                idx_reg   <= saddr_t'(1);
                                j_reg     <= '0;
                                iter_reg  <= '0;
                                state_reg <= ST_K1_RD;
                            end
                            OP_DRAW: begin
                                idx_reg   <= '0;
                                state_reg <= ST_TW_START;
                            end
                            default: begin
                                state_reg <= ST_EMIT;
                            end
                        endcase
                    end
                end
                ST_K1_RD: begin
                    prod_reg  <= mult_out;
                    state_reg <= ST_K1_EX;
                end
                ST_K1_EX: begin
                    p_reg    <= key_mix;
                    idx_reg  <= (idx_reg == LAST_WORD) ? saddr_t'(1) : idx_reg + saddr_t'(1);
                    j_reg    <= (j_inc >= count_reg) ? '0 : KAW'(j_inc);
                    iter_reg <= iter_reg + saddr_t'(1);
                    if (iter_reg == LAST_WORD) begin
                        iter_reg  <= '0;
                        state_reg <= ST_K2_RD;
                    end else begin
                        state_reg <= ST_K1_RD;
                    end
                end
                ST_K2_RD: begin
                    prod_reg  <= mult_out;
                    state_reg <= ST_K2_EX;
                end
                ST_K2_EX: begin
                    p_reg    <= key_fold;
                    idx_reg  <= (idx_reg == LAST_WORD) ? saddr_t'(1) : idx_reg + saddr_t'(1);
                    iter_reg <= iter_reg + saddr_t'(1);
                    if (iter_reg == LAST_WORD - saddr_t'(1)) begin
                        state_reg <= ST_KFIN;
                    end else begin
                        state_reg <= ST_K2_RD;
                    end
                end
                ST_KFIN: begin
                    pos_reg   <= POS_EXPIRED;
                    state_reg <= ST_EMIT;
                end
                ST_TW_START: begin
                    idx_reg   <= '0;
                    state_reg <= ST_TW_FIRST;
                end
                ST_TW_FIRST: begin
                    hi_reg    <= mt_rdata_a[31];
                    state_reg <= ST_TW_RD;
                end
                ST_TW_RD: begin
                    state_reg <= ST_TW_EX;
                end
                ST_TW_EX: begin
                    hi_reg  <= mt_rdata_a[31];
                    idx_reg <= idx_reg + saddr_t'(1);
                    if (idx_reg == LAST_WORD) begin
                        pos_reg   <= '0;
                        state_reg <= ST_DR_RD;
                    end else begin
                        state_reg <= ST_TW_RD;
                    end
                end
                ST_DR_RD: begin
                    state_reg <= ST_DR_EX;
                end
                ST_DR_EX: begin
                    pos_reg   <= pos_reg + saddr_t'(1);
                    state_reg <= ST_EMIT;
                end
                ST_EMIT: begin
                    // Hold the result until the output register is free
                    if (emit_go) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_word_reg <= '0;
            res_flag_reg <= (s_op == OP_DRAW);
        end else if (state_reg == ST_DR_EX) begin
            res_word_reg <= tempered;
        end
        if (emit_go) begin
            m_word_reg <= res_word_reg;
            m_flag_reg <= res_flag_reg;
        end
    end

    `MTG_ASSERT(a_pos_range, aclk, aresetn, pos_reg <= NEVER_SEEDED, "read position out of range")
    `MTG_ASSERT(a_accept_busy, aclk, aresetn, accept |=> state_reg != ST_IDLE, "accept did not start work")
    `MTG_ASSERT(a_draw_emits, aclk, aresetn, state_reg == ST_DR_EX |=> (state_reg == ST_EMIT && res_flag_reg), "draw did not reach result stage")
    `MTG_ASSERT(a_key_index, aclk, aresetn, (state_reg == ST_K1_EX) |-> (CW'(j_reg) < count_reg), "key index beyond key count")
    `MTG_ASSERT(a_zero_result, aclk, aresetn, (m_valid && !m_word_valid) |-> (m_random_word == 32'd0), "non-draw result carries a word")

endmodule
